@@ sv/assert_macros.svh @@
// Assertion macros for the files that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge of i_clk while the block is out of reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked on every rising edge of i_clk, also during reset.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

@@ sv/ddph_pkg.sv @@
// Types, codes and digit arithmetic for the decimal digit pixel hider.
package ddph_pkg;

    typedef enum logic [1:0] {
        OP_HIDE      = 2'd0,
        OP_FINISH    = 2'd1,
        OP_NORMALIZE = 2'd2
    } t_op;

    localparam logic [7:0] FINISH_RED_DIGIT = 8'd3;
    localparam logic [7:0] FALLBACK_RED_DIGIT = 8'd4;
    localparam logic [7:0] NORMAL_DIGIT = 8'd5;
    localparam logic [3:0] DIGIT_CAP = 4'd5;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] data_byte;
        logic [7:0] first_red;
        logic [7:0] first_green;
        logic [7:0] first_blue;
        logic [7:0] second_red;
        logic [7:0] second_green;
        logic [7:0] second_blue;
    } t_in_item;

    typedef struct packed {
        logic       pixel_offset;
        logic [7:0] new_red;
        logic [7:0] new_green;
        logic [7:0] new_blue;
        logic       last_write;
    } t_out_item;

    typedef struct packed {
        logic      has_first;
        logic      has_second;
        t_out_item first_res;
        t_out_item second_res;
    } t_core_res;

    typedef struct packed {
        logic [1:0] hun;
        logic [3:0] ten;
        logic [3:0] uni;
    } t_digits;

    // Rounds down to a multiple of ten; 205/2048 is exact for every 8-bit value.
    function automatic logic [7:0] round_down10(input logic [7:0] c);
        logic [15:0] prod;
        logic [4:0]  q;
        prod = 16'(c) * 16'd205;
        q = prod[15:11];
        return {q, 3'b000} + {2'b00, q, 1'b0};
    endfunction

    function automatic t_digits split_digits(input logic [7:0] b);
        logic [15:0] prod_h;
        logic [15:0] prod_t;
        logic [1:0]  hun;
        logic [6:0]  rem;
        logic [3:0]  ten;
        logic [6:0]  ten10;
        t_digits     d;
        prod_h = 16'(b) * 16'd41;
        hun = prod_h[13:12];
        rem = 7'(b - 8'(8'(hun) * 8'd100));
        prod_t = 16'(rem) * 16'd205;
        ten = prod_t[14:11];
        ten10 = 7'(7'(ten) * 7'd10);
        d.hun = hun;
        d.ten = ten;
        d.uni = 4'(rem - ten10);
        return d;
    endfunction

endpackage

@@ sv/ddph_if.sv @@
// Valid/ready channel interfaces for the input items and the pixel writes.
interface ddph_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] op;
    logic [7:0] data_byte;
    logic [7:0] first_red;
    logic [7:0] first_green;
    logic [7:0] first_blue;
    logic [7:0] second_red;
    logic [7:0] second_green;
    logic [7:0] second_blue;

    modport source (
        output valid, op, data_byte, first_red, first_green, first_blue,
               second_red, second_green, second_blue,
        input  ready
    );
    modport sink (
        input  valid, op, data_byte, first_red, first_green, first_blue,
               second_red, second_green, second_blue,
        output ready
    );
endinterface

interface ddph_out_if;
    logic       valid;
    logic       ready;
    logic       pixel_offset;
    logic [7:0] new_red;
    logic [7:0] new_green;
    logic [7:0] new_blue;
    logic       last_write;

    modport source (
        output valid, pixel_offset, new_red, new_green, new_blue, last_write,
        input  ready
    );
    modport sink (
        input  valid, pixel_offset, new_red, new_green, new_blue, last_write,
        output ready
    );
endinterface

@@ sv/decimal_digit_pixel_hider.sv @@
// An accepted item goes into the input register, and its first write is loaded from there into the output register.
// Throughput: one item per cycle while o_out.ready holds; an item whose digits overflow
// makes two pixel writes, and the input stalls until the second one leaves.
// The block holds an input register and a two-entry output register (current and pending write).
// Reset: i_rst_n is synchronous, active low, and empties both registers.
module decimal_digit_pixel_hider
    import ddph_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    ddph_in_if.sink       i_in,
    ddph_out_if.source    o_out
);

`include "assert_macros.svh"

    logic      r_in_valid, n_in_valid;
    t_in_item  r_in, n_in;
    logic      r_out_valid, n_out_valid;
    logic      r_pend_valid, n_pend_valid;
    t_out_item r_out, n_out;
    t_out_item r_pend, n_pend;
    t_core_res core_res;
    logic      out_free;
    logic      in_ready;

    ddph_core u_core (
        .i_item (r_in),
        .o_res  (core_res)
    );

    // The output side can take a new item once its last pending write leaves.
    assign out_free = !r_out_valid || (o_out.ready && !r_pend_valid);
    assign in_ready = !r_in_valid || out_free;

    always_comb begin
        n_in_valid = r_in_valid;
        n_in = r_in;
        if (in_ready) begin
            n_in_valid = i_in.valid;
            n_in = '{op: i_in.op, data_byte: i_in.data_byte,
                     first_red: i_in.first_red, first_green: i_in.first_green,
                     first_blue: i_in.first_blue, second_red: i_in.second_red,
                     second_green: i_in.second_green, second_blue: i_in.second_blue};
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        n_pend_valid = r_pend_valid;
        n_out = r_out;
        n_pend = r_pend;
        if (out_free) begin
            n_out_valid = r_in_valid && core_res.has_first;
            n_pend_valid = r_in_valid && core_res.has_second;
            n_out = core_res.first_res;
            n_pend = core_res.second_res;
        end else if (o_out.ready) begin
            n_out_valid = 1'b1;
            n_pend_valid = 1'b0;
            n_out = r_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_out_valid <= 1'b0;
            r_pend_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
            r_out_valid <= n_out_valid;
            r_pend_valid <= n_pend_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_in <= n_in;
        r_out <= n_out;
        r_pend <= n_pend;
    end

    assign i_in.ready = in_ready;
    assign o_out.valid = r_out_valid;
    assign o_out.pixel_offset = r_out.pixel_offset;
    assign o_out.new_red = r_out.new_red;
    assign o_out.new_green = r_out.new_green;
    assign o_out.new_blue = r_out.new_blue;
    assign o_out.last_write = r_out.last_write;

    `ASSERT_CLK(a_pend_needs_out, r_pend_valid |-> r_out_valid, "pending write without a current write")
    `ASSERT_CLK(a_pend_first_write, r_pend_valid |-> (!r_out.pixel_offset && !r_out.last_write), "first of two writes is malformed")
    `ASSERT_CLK(a_second_follows, (o_out.valid && o_out.ready && !o_out.last_write) |=> (o_out.valid && o_out.pixel_offset && o_out.last_write), "following-pixel write missing")
    `ASSERT_ALWAYS(a_reset_empty, !$past(i_rst_n) |-> (!r_out_valid && !r_pend_valid && !r_in_valid), "registers not empty after reset")

endmodule

@@ sv/ddph_core.sv @@
// Combinational digit logic that turns one input item into its pixel writes.
module ddph_core
    import ddph_pkg::*;
(
    input  t_in_item  i_item,
    output t_core_res o_res
);

    logic [7:0] r1, g1, b1, r2, g2, b2;
    t_digits    dig;
    logic [8:0] g_sum, b_sum;
    logic       ovf;
    logic [3:0] cap_t, cap_u, ext_t, ext_u;

    assign r1 = round_down10(i_item.first_red);
    assign g1 = round_down10(i_item.first_green);
    assign b1 = round_down10(i_item.first_blue);
    assign r2 = round_down10(i_item.second_red);
    assign g2 = round_down10(i_item.second_green);
    assign b2 = round_down10(i_item.second_blue);
    assign dig = split_digits(i_item.data_byte);

    assign g_sum = {1'b0, g1} + 9'(dig.ten);
    assign b_sum = {1'b0, b1} + 9'(dig.uni);
    assign ovf = g_sum[8] | b_sum[8];

    assign cap_t = (dig.ten > DIGIT_CAP) ? DIGIT_CAP : dig.ten;
    assign cap_u = (dig.uni > DIGIT_CAP) ? DIGIT_CAP : dig.uni;
    assign ext_t = (dig.ten > DIGIT_CAP) ? 4'(dig.ten - DIGIT_CAP) : 4'd0;
    assign ext_u = (dig.uni > DIGIT_CAP) ? 4'(dig.uni - DIGIT_CAP) : 4'd0;

    always_comb begin
        o_res.has_first = 1'b0;
        o_res.has_second = 1'b0;
        o_res.first_res = '{pixel_offset: 1'b0, new_red: r1, new_green: g1,
                            new_blue: b1, last_write: 1'b1};
        o_res.second_res = '{pixel_offset: 1'b1, new_red: r2 + 8'(dig.hun),
                             new_green: g2 + 8'(ext_t), new_blue: b2 + 8'(ext_u),
                             last_write: 1'b1};
        case (t_op'(i_item.op))
            OP_FINISH: begin
                o_res.has_first = 1'b1;
                o_res.first_res.new_red = r1 + FINISH_RED_DIGIT;
            end
            OP_NORMALIZE: begin
                o_res.has_first = 1'b1;
                o_res.first_res.new_red = r1 + NORMAL_DIGIT;
                o_res.first_res.new_green = g1 + NORMAL_DIGIT;
                o_res.first_res.new_blue = b1 + NORMAL_DIGIT;
            end
            OP_HIDE: begin
                o_res.has_first = 1'b1;
                if (ovf) begin
                    // Digits do not fit: mark the pixel 4XY and spill into the next one.
                    o_res.has_second = 1'b1;
                    o_res.first_res.new_red = r1 + FALLBACK_RED_DIGIT;
                    o_res.first_res.new_green = g1 + 8'(cap_t);
                    o_res.first_res.new_blue = b1 + 8'(cap_u);
                    o_res.first_res.last_write = 1'b0;
                end else begin
                    o_res.first_res.new_red = r1 + 8'(dig.hun);
                    o_res.first_res.new_green = g_sum[7:0];
                    o_res.first_res.new_blue = b_sum[7:0];
                end
            end
            default: begin
                o_res.has_first = 1'b0;
            end
        endcase
    end

endmodule

@@ tb/tb.sv @@
// Self-checking testbench for decimal_digit_pixel_hider with its own pixel write predictor.
`timescale 1ns / 1ps

module tb;
    import ddph_pkg::*;

    // The package leaves the fourth selector value unnamed; the block drops such items.
    localparam logic [1:0] OP_UNUSED = 2'd3;

    class pixel_write_scoreboard;
        t_out_item expected_writes[$];
        int        mismatches;

        function logic [7:0] floor_ten(input logic [7:0] c);
            return c - c % 8'd10;
        endfunction

        function t_out_item pixel_write(input logic off, input int r, input int g,
                                        input int b, input logic last);
            t_out_item w;
            w.pixel_offset = off;
            w.new_red      = 8'(r);
            w.new_green    = 8'(g);
            w.new_blue     = 8'(b);
            w.last_write   = last;
            return w;
        endfunction

        // Works out the pixel writes that one accepted item must cause.
        function void note_input(input t_in_item it);
            int r1, g1, b1, r2, g2, b2;
            int hun, ten, uni, cap_ten, cap_uni;
            r1  = floor_ten(it.first_red);
            g1  = floor_ten(it.first_green);
            b1  = floor_ten(it.first_blue);
            r2  = floor_ten(it.second_red);
            g2  = floor_ten(it.second_green);
            b2  = floor_ten(it.second_blue);
            hun = it.data_byte / 100;
            ten = (it.data_byte % 100) / 10;
            uni = it.data_byte % 10;
            case (it.op)
                OP_FINISH: begin
                    expected_writes.push_back(pixel_write(1'b0, r1 + FINISH_RED_DIGIT,
                                                          g1, b1, 1'b1));
                end
                OP_NORMALIZE: begin
                    expected_writes.push_back(pixel_write(1'b0, r1 + NORMAL_DIGIT,
                                                          g1 + NORMAL_DIGIT,
                                                          b1 + NORMAL_DIGIT, 1'b1));
                end
                OP_HIDE: begin
                    if (g1 + ten <= 255 && b1 + uni <= 255) begin
                        expected_writes.push_back(pixel_write(1'b0, r1 + hun, g1 + ten,
                                                              b1 + uni, 1'b1));
                    end else begin
                        // Digits that do not fit spill their excess over five into
                        // the following pixel, which also takes the hundreds digit.
                        cap_ten = ten > 5 ? 5 : ten;
                        cap_uni = uni > 5 ? 5 : uni;
                        expected_writes.push_back(pixel_write(1'b0, r1 + FALLBACK_RED_DIGIT,
                                                              g1 + cap_ten, b1 + cap_uni,
                                                              1'b0));
                        expected_writes.push_back(pixel_write(1'b1, r2 + hun,
                                                              g2 + ten - cap_ten,
                                                              b2 + uni - cap_uni, 1'b1));
                    end
                end
                default: ;
            endcase
        endfunction

        task report(input string what);
            mismatches++;
            if (mismatches <= 40) $display("mismatch: %s", what);
        endtask

        task check_write(input t_out_item got);
            t_out_item want;
            if (expected_writes.size() == 0) begin
                report($sformatf("write with nothing pending: %p", got));
                return;
            end
            want = expected_writes.pop_front();
            if (got.pixel_offset !== want.pixel_offset)
                report($sformatf("pixel_offset %0d, wanted %0d",
                                 got.pixel_offset, want.pixel_offset));
            if (got.new_red !== want.new_red)
                report($sformatf("new_red %0d, wanted %0d", got.new_red, want.new_red));
            if (got.new_green !== want.new_green)
                report($sformatf("new_green %0d, wanted %0d", got.new_green, want.new_green));
            if (got.new_blue !== want.new_blue)
                report($sformatf("new_blue %0d, wanted %0d", got.new_blue, want.new_blue));
            if (got.last_write !== want.last_write)
                report($sformatf("last_write %0d, wanted %0d",
                                 got.last_write, want.last_write));
        endtask
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    ddph_in_if  in_if();
    ddph_out_if out_if();

    pixel_write_scoreboard sb;
    int  accepted_jobs;
    int  hold_requests;
    int  holds_served;
    bit  rx_holding;

    decimal_digit_pixel_hider i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    always #1 i_clk = ~i_clk;

    initial begin
        #400000;
        $display("decimal_digit_pixel_hider regression: fail");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready)
            sb.check_write(t_out_item'{out_if.pixel_offset, out_if.new_red,
                                       out_if.new_green, out_if.new_blue,
                                       out_if.last_write});
    end

    // Receiver: stretches of always ready, random stalls, mostly stalled and alternating,
    // plus a long hold-off whenever the sender asks for one.
    initial begin
        int  seg_len;
        int  mode;
        bit  toggle;
        out_if.ready = 1'b0;
        toggle = 1'b0;
        forever begin
            if (hold_requests != holds_served) begin
                holds_served++;
                rx_holding = 1'b1;
                @(negedge i_clk);
                out_if.ready <= 1'b0;
                repeat (60) @(negedge i_clk);
                rx_holding = 1'b0;
            end else begin
                seg_len = $urandom_range(1, 30);
                mode    = $urandom_range(0, 3);
                repeat (seg_len) begin
                    @(negedge i_clk);
                    toggle = ~toggle;
                    case (mode)
                        0:       out_if.ready <= 1'b1;
                        1:       out_if.ready <= 1'($urandom_range(0, 1));
                        2:       out_if.ready <= ($urandom_range(0, 3) == 0);
                        default: out_if.ready <= toggle;
                    endcase
                end
            end
        end
    end

    function automatic t_in_item make_job(input logic [1:0] op, input logic [7:0] hb,
                                          input logic [7:0] r1, input logic [7:0] g1,
                                          input logic [7:0] b1, input logic [7:0] r2,
                                          input logic [7:0] g2, input logic [7:0] b2);
        return t_in_item'{op, hb, r1, g1, b1, r2, g2, b2};
    endfunction

    // Hide items dominate, often with green or blue near the top so the digits overflow.
    function automatic t_in_item random_job();
        t_in_item it;
        int       pick;
        it = make_job(OP_HIDE, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                      8'($urandom), 8'($urandom), 8'($urandom));
        pick = $urandom_range(0, 99);
        if (pick < 50) begin
            if ($urandom_range(0, 1)) it.first_green = 8'($urandom_range(240, 255));
            if ($urandom_range(0, 1)) it.first_blue  = 8'($urandom_range(240, 255));
        end else if (pick < 68) begin
            it.op = OP_FINISH;
        end else if (pick < 86) begin
            it.op = OP_NORMALIZE;
        end else if (pick < 93) begin
            it.op = OP_UNUSED;
        end
        return it;
    endfunction

    task automatic send_item(input t_in_item it);
        @(negedge i_clk);
        in_if.valid        <= 1'b1;
        in_if.op           <= it.op;
        in_if.data_byte    <= it.data_byte;
        in_if.first_red    <= it.first_red;
        in_if.first_green  <= it.first_green;
        in_if.first_blue   <= it.first_blue;
        in_if.second_red   <= it.second_red;
        in_if.second_green <= it.second_green;
        in_if.second_blue  <= it.second_blue;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        sb.note_input(it);
        if (it.op != OP_UNUSED) accepted_jobs++;
    endtask

    task automatic idle_sender(input int n);
        repeat (n) begin
            @(negedge i_clk);
            in_if.valid <= 1'b0;
        end
    endtask

    task automatic wait_for_writes();
        idle_sender(1);
        while (sb.expected_writes.size() != 0) @(posedge i_clk);
    endtask

    initial begin
        t_in_item directed[$];
        int       burst_len;
        bit       hold_done;
        bit       pause_done;
        sb = new();
        accepted_jobs      = 0;
        hold_requests      = 0;
        holds_served       = 0;
        rx_holding         = 1'b0;
        hold_done          = 1'b0;
        pause_done         = 1'b0;
        i_rst_n            = 1'b0;
        in_if.valid        = 1'b0;
        in_if.op           = OP_HIDE;
        in_if.data_byte    = '0;
        in_if.first_red    = '0;
        in_if.first_green  = '0;
        in_if.first_blue   = '0;
        in_if.second_red   = '0;
        in_if.second_green = '0;
        in_if.second_blue  = '0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        directed.push_back(make_job(OP_HIDE, 0, 0, 0, 0, 0, 0, 0));
        // Green and blue land exactly on 255: still a single write.
        directed.push_back(make_job(OP_HIDE, 255, 255, 255, 255, 255, 255, 255));
        directed.push_back(make_job(OP_HIDE, 199, 12, 250, 37, 255, 255, 255));
        directed.push_back(make_job(OP_HIDE, 206, 0, 0, 255, 0, 0, 0));
        directed.push_back(make_job(OP_HIDE, 60, 99, 250, 0, 128, 64, 32));
        directed.push_back(make_job(OP_HIDE, 56, 7, 250, 250, 9, 19, 29));
        directed.push_back(make_job(OP_HIDE, 55, 250, 250, 250, 1, 2, 3));
        directed.push_back(make_job(OP_HIDE, 100, 123, 45, 67, 89, 10, 11));
        directed.push_back(make_job(OP_HIDE, 9, 0, 0, 249, 0, 0, 0));
        directed.push_back(make_job(OP_HIDE, 99, 255, 255, 255, 0, 0, 0));
        directed.push_back(make_job(OP_HIDE, 250, 1, 2, 3, 4, 5, 6));
        directed.push_back(make_job(OP_HIDE, 197, 0, 245, 250, 170, 85, 254));
        directed.push_back(make_job(OP_FINISH, 0, 0, 0, 0, 0, 0, 0));
        directed.push_back(make_job(OP_FINISH, 255, 255, 255, 255, 255, 255, 255));
        directed.push_back(make_job(OP_FINISH, 77, 88, 99, 111, 200, 201, 202));
        directed.push_back(make_job(OP_NORMALIZE, 0, 0, 0, 0, 0, 0, 0));
        directed.push_back(make_job(OP_NORMALIZE, 255, 255, 255, 255, 255, 255, 255));
        directed.push_back(make_job(OP_NORMALIZE, 170, 9, 19, 29, 39, 49, 59));
        directed.push_back(make_job(OP_UNUSED, 255, 255, 255, 255, 255, 255, 255));
        directed.push_back(make_job(OP_UNUSED, 0, 0, 0, 0, 0, 0, 0));
        foreach (directed[i]) begin
            send_item(directed[i]);
            if ($urandom_range(0, 2) == 0) idle_sender($urandom_range(1, 4));
        end
        wait_for_writes();

        accepted_jobs = 0;
        while (accepted_jobs < 600) begin
            if (!hold_done && accepted_jobs >= 200) begin
                // The receiver stops for a long stretch while items keep coming.
                hold_done = 1'b1;
                hold_requests++;
                while (!rx_holding) idle_sender(1);
                repeat (30) send_item(random_job());
            end
            if (!pause_done && accepted_jobs >= 400) begin
                pause_done = 1'b1;
                wait_for_writes();
            end
            burst_len = $urandom_range(1, 20);
            repeat (burst_len) send_item(random_job());
            if ($urandom_range(0, 3) != 0) idle_sender($urandom_range(1, 8));
        end

        wait_for_writes();
        repeat (10) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.expected_writes.size() == 0) begin
            $display("decimal_digit_pixel_hider regression: pass");
        end else begin
            $display("decimal_digit_pixel_hider regression: fail");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+sv
sv/ddph_pkg.sv
sv/ddph_if.sv
sv/ddph_core.sv
sv/decimal_digit_pixel_hider.sv
tb/tb.sv
